// ===== hdl/i2cmbw_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmbw_pkg
// shared types and constants of the i2c master byte write block
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbw_pkg;

  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;
  localparam int OUT_FIFO_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_DELAY     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRETCH_TIMEOUT = 1'd1;

  localparam logic [7:0]  PHASE_DELAY_RESET     = 8'd5;
  localparam logic [15:0] STRETCH_TIMEOUT_RESET = 16'hFFFF;

  localparam logic OPC_TICK  = 1'b0;
  localparam logic OPC_START = 1'b1;

  localparam int LINE_SCL_BIT   = 0;
  localparam int LINE_SDA_BIT   = 1;
  localparam int FLAG_NACK_BIT  = 0;
  localparam int FLAG_STUCK_BIT = 1;
  localparam int MSB_BIT        = 7;

  typedef struct packed {
    logic [7:0]  phase_delay;
    logic [15:0] stretch_timeout;
  } cfg_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] address_byte;
    logic [7:0] data_byte;
    logic       scl_sample;
    logic       sda_sample;
  } in_word_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [1:0] error_flags;
  } res_word_t;

endpackage

`default_nettype wire

// ===== hdl/i2cmbw_if.sv =====
// ----------------------------------------------------------------------------
// i2cmbw interfaces
// valid/ready channels for command words, result words and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cmbw_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] address_byte;
  logic [7:0] data_byte;
  logic       scl_sample;
  logic       sda_sample;

  modport source (output valid, opcode, address_byte, data_byte, scl_sample, sda_sample,
                  input ready);
  modport sink   (input valid, opcode, address_byte, data_byte, scl_sample, sda_sample,
                  output ready);
endinterface

interface i2cmbw_out_if;
  logic       valid;
  logic       ready;
  logic       scl_release;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [1:0] error_flags;

  modport source (output valid, scl_release, sda_release, busy_res, done_res, error_flags,
                  input ready);
  modport sink   (input valid, scl_release, sda_release, busy_res, done_res, error_flags,
                  output ready);
endinterface

interface i2cmbw_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [i2cmbw_pkg::CFG_IDX_W-1:0]  index;
  logic [i2cmbw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/i2cmbw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// i2cmbw_cfg_regs
// phase delay and clock stretch timeout registers
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmbw_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              wr_en,
  input  wire logic [i2cmbw_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [i2cmbw_pkg::CFG_DATA_W-1:0] wr_data,
  output i2cmbw_pkg::cfg_t                       cfg
);

  i2cmbw_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_delay     <= i2cmbw_pkg::PHASE_DELAY_RESET;
      cfg_r.stretch_timeout <= i2cmbw_pkg::STRETCH_TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        i2cmbw_pkg::REG_PHASE_DELAY:     cfg_r.phase_delay     <= wr_data[7:0];
        i2cmbw_pkg::REG_STRETCH_TIMEOUT: cfg_r.stretch_timeout <= wr_data[15:0];
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hdl/i2cmbw_core.sv =====
// ----------------------------------------------------------------------------
// i2cmbw_core
// one bus phase step per command word, result word formed in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmbw_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire i2cmbw_pkg::in_word_t in_word,
  input  wire i2cmbw_pkg::cfg_t cfg,
  output i2cmbw_pkg::res_word_t res_word
);

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_START_C   = 4'd3,
    PH_BIT_WAIT  = 4'd4,
    PH_BIT_HIGH  = 4'd5,
    PH_BIT_LOW   = 4'd6,
    PH_ACK_WAIT  = 4'd7,
    PH_ACK_HIGH  = 4'd8,
    PH_ACK_LOW   = 4'd9,
    PH_STOP_A    = 4'd10,
    PH_STOP_WAIT = 4'd11,
    PH_STOP_B    = 4'd12,
    PH_STOP_C    = 4'd13
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  bit_idx_r, bit_idx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  delay_r, delay_nxt;
  logic [15:0] stretch_r, stretch_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic [1:0]  line_r, line_nxt;
  logic        done_nxt;

  logic [7:0]  arm_val;
  logic        delay_done;
  logic [7:0]  delay_dec;
  logic [15:0] stretch_inc;
  logic [15:0] stretch_limit;
  logic        stuck;
  logic        scl_up;

  always_comb begin
    arm_val       = (cfg.phase_delay == 8'd0) ? 8'd1 : cfg.phase_delay;
    delay_done    = (delay_r <= 8'd1);
    delay_dec     = delay_done ? 8'd0 : (delay_r - 8'd1);
    stretch_inc   = (stretch_r != 16'hFFFF) ? (stretch_r + 16'd1) : stretch_r;
    stretch_limit = (cfg.stretch_timeout == 16'd0) ? 16'd1 : cfg.stretch_timeout;
    stuck         = !in_word.scl_sample && (stretch_inc >= stretch_limit);
    scl_up        = in_word.scl_sample || stuck;
  end

  always_comb begin
    phase_nxt   = phase_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    held_nxt    = held_r;
    delay_nxt   = delay_r;
    stretch_nxt = stretch_r;
    flags_nxt   = flags_r;
    line_nxt    = line_r;
    done_nxt    = 1'b0;

    unique case (phase_r)
      PH_START_A: begin
        delay_nxt = delay_dec;
        if (delay_done) begin
          line_nxt[i2cmbw_pkg::LINE_SDA_BIT] = 1'b0;
          delay_nxt = arm_val;
          phase_nxt = PH_START_B;
        end
      end
      PH_START_B: begin
        delay_nxt = delay_dec;
        if (delay_done) begin
          line_nxt[i2cmbw_pkg::LINE_SCL_BIT] = 1'b0;
          delay_nxt = arm_val;
          phase_nxt = PH_START_C;
        end
      end
      PH_START_C: begin
        delay_nxt = delay_dec;
        if (delay_done) begin
          line_nxt[i2cmbw_pkg::LINE_SDA_BIT] = shift_r[i2cmbw_pkg::MSB_BIT];
          line_nxt[i2cmbw_pkg::LINE_SCL_BIT] = 1'b1;
          stretch_nxt = 16'd0;
          phase_nxt   = PH_BIT_WAIT;
        end
      end
      PH_BIT_WAIT, PH_ACK_WAIT, PH_STOP_WAIT: begin
        if (!in_word.scl_sample) begin
          stretch_nxt = stretch_inc;
        end
        if (stuck) begin
          flags_nxt[i2cmbw_pkg::FLAG_STUCK_BIT] = 1'b1;
        end
        if (scl_up) begin
          delay_nxt = arm_val;
          if (phase_r == PH_BIT_WAIT) begin
            phase_nxt = PH_BIT_HIGH;
          end else if (phase_r == PH_ACK_WAIT) begin
            phase_nxt = PH_ACK_HIGH;
          end else begin
            phase_nxt = PH_STOP_B;
          end
        end
      end
      PH_BIT_HIGH: begin
        delay_nxt = delay_dec;
        if (delay_done) begin
          line_nxt[i2cmbw_pkg::LINE_SCL_BIT] = 1'b0;
          delay_nxt = arm_val;
          phase_nxt = PH_BIT_LOW;
        end
      end
      PH_BIT_LOW: begin
        delay_nxt = delay_dec;
        if (delay_done) begin
          shift_nxt   = {shift_r[6:0], 1'b0};
          bit_idx_nxt = bit_idx_r + 4'd1;
          line_nxt[i2cmbw_pkg::LINE_SCL_BIT] = 1'b1;
          stretch_nxt = 16'd0;
          if (bit_idx_nxt[2:0] != 3'd0) begin
            line_nxt[i2cmbw_pkg::LINE_SDA_BIT] = shift_r[i2cmbw_pkg::MSB_BIT-1];
            phase_nxt = PH_BIT_WAIT;
          end else begin
            line_nxt[i2cmbw_pkg::LINE_SDA_BIT] = 1'b1;
            phase_nxt = PH_ACK_WAIT;
          end
        end
      end
      PH_ACK_HIGH: begin
        delay_nxt = delay_dec;
        if (delay_done) begin
          if (in_word.sda_sample) begin
            flags_nxt[i2cmbw_pkg::FLAG_NACK_BIT] = 1'b1;
          end
          line_nxt[i2cmbw_pkg::LINE_SCL_BIT] = 1'b0;
          delay_nxt = arm_val;
          phase_nxt = PH_ACK_LOW;
        end
      end
      PH_ACK_LOW: begin
        delay_nxt = delay_dec;
        if (delay_done) begin
          if (bit_idx_r == 4'd8) begin
            shift_nxt = held_r;
            line_nxt[i2cmbw_pkg::LINE_SDA_BIT] = held_r[i2cmbw_pkg::MSB_BIT];
            line_nxt[i2cmbw_pkg::LINE_SCL_BIT] = 1'b1;
            stretch_nxt = 16'd0;
            phase_nxt   = PH_BIT_WAIT;
          end else begin
            line_nxt[i2cmbw_pkg::LINE_SDA_BIT] = 1'b0;
            delay_nxt = arm_val;
            phase_nxt = PH_STOP_A;
          end
        end
      end
      PH_STOP_A: begin
        delay_nxt = delay_dec;
        if (delay_done) begin
          line_nxt[i2cmbw_pkg::LINE_SCL_BIT] = 1'b1;
          stretch_nxt = 16'd0;
          phase_nxt   = PH_STOP_WAIT;
        end
      end
      PH_STOP_B: begin
        delay_nxt = delay_dec;
        if (delay_done) begin
          line_nxt[i2cmbw_pkg::LINE_SDA_BIT] = 1'b1;
          delay_nxt = arm_val;
          phase_nxt = PH_STOP_C;
        end
      end
      PH_STOP_C: begin
        delay_nxt = delay_dec;
        if (delay_done) begin
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (in_word.opcode == i2cmbw_pkg::OPC_START) begin
          flags_nxt   = 2'b00;
          shift_nxt   = in_word.address_byte;
          held_nxt    = in_word.data_byte;
          bit_idx_nxt = 4'd0;
          stretch_nxt = 16'd0;
          line_nxt    = 2'b11;
          delay_nxt   = arm_val;
          phase_nxt   = PH_START_A;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_idx_r <= 4'd0;
      shift_r   <= 8'd0;
      held_r    <= 8'd0;
      delay_r   <= 8'd0;
      stretch_r <= 16'd0;
      flags_r   <= 2'b00;
      line_r    <= 2'b11;
    end else if (step) begin
      phase_r   <= phase_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      held_r    <= held_nxt;
      delay_r   <= delay_nxt;
      stretch_r <= stretch_nxt;
      flags_r   <= flags_nxt;
      line_r    <= line_nxt;
    end
  end

  always_comb begin
    res_word.scl_release = line_nxt[i2cmbw_pkg::LINE_SCL_BIT];
    res_word.sda_release = line_nxt[i2cmbw_pkg::LINE_SDA_BIT];
    res_word.busy_res    = (phase_nxt != PH_IDLE);
    res_word.done_res    = done_nxt;
    res_word.error_flags = flags_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/i2cmbw_out_fifo.sv =====
// ----------------------------------------------------------------------------
// i2cmbw_out_fifo
// small result word queue between the phase logic and the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmbw_out_fifo #(
  parameter int DEPTH = i2cmbw_pkg::OUT_FIFO_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire i2cmbw_pkg::res_word_t push_word,
  output logic                  not_full,
  input  wire logic             pop,
  output logic                  not_empty,
  output i2cmbw_pkg::res_word_t head_word
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  i2cmbw_pkg::res_word_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : (wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : (rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  assign not_full  = (count_r != FULL);
  assign not_empty = (count_r != '0);
  assign head_word = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== hdl/i2c_master_byte_write.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_write
// tick driven i2c master doing one single byte write transaction per command
// ----------------------------------------------------------------------------
// a result word is formed with its command word's step and registered in the result queue before it is offered
// throughput: one word per cycle while the result queue has room, else the input stalls
// a two word result queue lets commands flow while one result waits
// reset: synchronous active low rst_n, bus phase idle, both lines released,
// flags and counters cleared, phase delay 5 and stretch timeout 65535
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_write #(
  parameter int OUT_DEPTH = i2cmbw_pkg::OUT_FIFO_DEPTH
) (
  input wire logic     clk,
  input wire logic     rst_n,
  i2cmbw_in_if.sink    in_ch,
  i2cmbw_out_if.source out_ch,
  i2cmbw_cfg_if.sink   cfg_ch
);

  i2cmbw_pkg::cfg_t      cfg;
  i2cmbw_pkg::in_word_t  in_word;
  i2cmbw_pkg::res_word_t res_word;
  i2cmbw_pkg::res_word_t head_word;
  logic                  in_take;
  logic                  fifo_not_full;
  logic                  fifo_not_empty;
  logic                  out_take;

  assign cfg_ch.ready = 1'b1;

  i2cmbw_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid && cfg_ch.ready),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  assign in_word = {in_ch.opcode, in_ch.address_byte, in_ch.data_byte,
                    in_ch.scl_sample, in_ch.sda_sample};

  assign in_ch.ready = fifo_not_full;
  assign in_take     = in_ch.valid && fifo_not_full;

  i2cmbw_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_take),
    .in_word  (in_word),
    .cfg      (cfg),
    .res_word (res_word)
  );

  assign out_take = fifo_not_empty && out_ch.ready;

  i2cmbw_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_word (res_word),
    .not_full  (fifo_not_full),
    .pop       (out_take),
    .not_empty (fifo_not_empty),
    .head_word (head_word)
  );

  assign out_ch.valid       = fifo_not_empty;
  assign out_ch.scl_release = head_word.scl_release;
  assign out_ch.sda_release = head_word.sda_release;
  assign out_ch.busy_res    = head_word.busy_res;
  assign out_ch.done_res    = head_word.done_res;
  assign out_ch.error_flags = head_word.error_flags;

endmodule

`default_nettype wire

// ===== hdl/i2cmbw_checker.sv =====
// ----------------------------------------------------------------------------
// i2cmbw_sva
// port level checks of the i2c master byte write block, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmbw_sva (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       scl_release,
  input wire logic       sda_release,
  input wire logic       busy_res,
  input wire logic       done_res,
  input wire logic [1:0] error_flags
);

  // queue only fills up while a result waits
  a_full_implies_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // stop completes with the bus idle and both lines free
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> !busy_res && scl_release && sda_release)
    else $error("done word not idle with released lines");

  // idle bus never holds a line low
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy_res |-> scl_release && sda_release)
    else $error("line driven low while idle");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid
      && $stable({scl_release, sda_release, busy_res, done_res, error_flags}))
    else $error("stalled result word changed");

endmodule

bind i2c_master_byte_write i2cmbw_sva u_i2cmbw_sva (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .scl_release (out_ch.scl_release),
  .sda_release (out_ch.sda_release),
  .busy_res    (out_ch.busy_res),
  .done_res    (out_ch.done_res),
  .error_flags (out_ch.error_flags)
);

`default_nettype wire

// ===== tb/i2cmbw_checker.sv =====
// ----------------------------------------------------------------------------
// i2cmbw_checker
// watches the command, result and register channels of the i2c master, keeps
// its own cycle model of the bus sequencer and compares every result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cmbw_checker (
  input  logic  clk,
  input  logic  rst_n,
  i2cmbw_in_if  in_ch,
  i2cmbw_out_if out_ch,
  i2cmbw_cfg_if cfg_ch,
  output int    n_fail,
  output int    n_pending,
  output bit    bus_busy
);

  typedef enum logic [3:0] {
    BUS_IDLE, BUS_START_A, BUS_START_B, BUS_START_C, BUS_BIT_WAIT, BUS_BIT_HIGH,
    BUS_BIT_LOW, BUS_ACK_WAIT, BUS_ACK_HIGH, BUS_ACK_LOW, BUS_STOP_A, BUS_STOP_WAIT,
    BUS_STOP_B, BUS_STOP_C
  } bus_phase_t;

  logic [7:0]              set_delay;
  logic [15:0]             set_timeout;
  bus_phase_t              bus_phase;
  logic [3:0]              bits_sent;
  logic [7:0]              shift_q;
  logic [7:0]              data_q;
  logic [7:0]              delay_left;
  logic [15:0]             low_ticks;
  logic [1:0]              err_q;
  logic                    scl_rel;
  logic                    sda_rel;
  i2cmbw_pkg::res_word_t   bus_view_q[$];

  task automatic report_fail(string msg);
    n_fail++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic void reset_bus_model();
    set_delay   = i2cmbw_pkg::PHASE_DELAY_RESET;
    set_timeout = i2cmbw_pkg::STRETCH_TIMEOUT_RESET;
    bus_phase   = BUS_IDLE;
    bits_sent   = '0;
    shift_q     = '0;
    data_q      = '0;
    delay_left  = '0;
    low_ticks   = '0;
    err_q       = '0;
    scl_rel     = 1'b1;
    sda_rel     = 1'b1;
  endfunction

  function automatic void arm_phase_delay();
    delay_left = (set_delay == 8'd0) ? 8'd1 : set_delay;
  endfunction

  function automatic logic phase_delay_done();
    if (delay_left <= 8'd1) begin
      delay_left = '0;
      return 1'b1;
    end
    delay_left = delay_left - 8'd1;
    return 1'b0;
  endfunction

  function automatic void release_scl(bus_phase_t nxt);
    scl_rel   = 1'b1;
    low_ticks = '0;
    bus_phase = nxt;
  endfunction

  // true once scl reads high or the stretch window has run out
  function automatic logic scl_is_up(logic scl);
    logic [16:0] limit;
    limit = (set_timeout == 16'd0) ? 17'd1 : {1'b0, set_timeout};
    if (scl) return 1'b1;
    if (low_ticks != 16'hFFFF) low_ticks = low_ticks + 16'd1;
    if ({1'b0, low_ticks} >= limit) begin
      err_q[i2cmbw_pkg::FLAG_STUCK_BIT] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void drive_next_bit();
    sda_rel = shift_q[i2cmbw_pkg::MSB_BIT];
    release_scl(BUS_BIT_WAIT);
  endfunction

  function automatic i2cmbw_pkg::res_word_t step_bus(i2cmbw_pkg::in_word_t w);
    i2cmbw_pkg::res_word_t r;
    logic                  fin;
    fin = 1'b0;
    case (bus_phase)
      BUS_START_A: if (phase_delay_done()) begin
        sda_rel = 1'b0;
        arm_phase_delay();
        bus_phase = BUS_START_B;
      end
      BUS_START_B: if (phase_delay_done()) begin
        scl_rel = 1'b0;
        arm_phase_delay();
        bus_phase = BUS_START_C;
      end
      BUS_START_C: if (phase_delay_done()) drive_next_bit();
      BUS_BIT_WAIT: if (scl_is_up(w.scl_sample)) begin
        arm_phase_delay();
        bus_phase = BUS_BIT_HIGH;
      end
      BUS_BIT_HIGH: if (phase_delay_done()) begin
        scl_rel = 1'b0;
        arm_phase_delay();
        bus_phase = BUS_BIT_LOW;
      end
      BUS_BIT_LOW: if (phase_delay_done()) begin
        shift_q   = shift_q << 1;
        bits_sent = bits_sent + 4'd1;
        if (bits_sent[2:0] != 3'd0) begin
          drive_next_bit();
        end else begin
          sda_rel = 1'b1;
          release_scl(BUS_ACK_WAIT);
        end
      end
      BUS_ACK_WAIT: if (scl_is_up(w.scl_sample)) begin
        arm_phase_delay();
        bus_phase = BUS_ACK_HIGH;
      end
      BUS_ACK_HIGH: if (phase_delay_done()) begin
        if (w.sda_sample) err_q[i2cmbw_pkg::FLAG_NACK_BIT] = 1'b1;
        scl_rel = 1'b0;
        arm_phase_delay();
        bus_phase = BUS_ACK_LOW;
      end
      BUS_ACK_LOW: if (phase_delay_done()) begin
        // address byte done: move on to the data byte, else stop
        if (bits_sent == 4'd8) begin
          shift_q = data_q;
          drive_next_bit();
        end else begin
          sda_rel = 1'b0;
          arm_phase_delay();
          bus_phase = BUS_STOP_A;
        end
      end
      BUS_STOP_A: if (phase_delay_done()) release_scl(BUS_STOP_WAIT);
      BUS_STOP_WAIT: if (scl_is_up(w.scl_sample)) begin
        arm_phase_delay();
        bus_phase = BUS_STOP_B;
      end
      BUS_STOP_B: if (phase_delay_done()) begin
        sda_rel = 1'b1;
        arm_phase_delay();
        bus_phase = BUS_STOP_C;
      end
      BUS_STOP_C: if (phase_delay_done()) begin
        bus_phase = BUS_IDLE;
        fin = 1'b1;
      end
      default: begin
        bus_phase = BUS_IDLE;
        if (w.opcode == i2cmbw_pkg::OPC_START) begin
          err_q     = '0;
          shift_q   = w.address_byte;
          data_q    = w.data_byte;
          bits_sent = '0;
          low_ticks = '0;
          scl_rel   = 1'b1;
          sda_rel   = 1'b1;
          arm_phase_delay();
          bus_phase = BUS_START_A;
        end
      end
    endcase
    r.scl_release = scl_rel;
    r.sda_release = sda_rel;
    r.busy_res    = (bus_phase != BUS_IDLE);
    r.done_res    = fin;
    r.error_flags = err_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    i2cmbw_pkg::in_word_t  w;
    i2cmbw_pkg::res_word_t got;
    i2cmbw_pkg::res_word_t want;
    if (!rst_n) begin
      reset_bus_model();
      bus_view_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == i2cmbw_pkg::REG_PHASE_DELAY) begin
          set_delay = cfg_ch.data[7:0];
        end else if (cfg_ch.index == i2cmbw_pkg::REG_STRETCH_TIMEOUT) begin
          set_timeout = cfg_ch.data;
        end
      end
      // results trail their command through the result queue, so pop before push
      if (out_ch.valid && out_ch.ready) begin
        got.scl_release = out_ch.scl_release;
        got.sda_release = out_ch.sda_release;
        got.busy_res    = out_ch.busy_res;
        got.done_res    = out_ch.done_res;
        got.error_flags = out_ch.error_flags;
        if (bus_view_q.size() == 0) begin
          report_fail("result word with no command outstanding");
        end else begin
          want = bus_view_q.pop_front();
          if (got.scl_release !== want.scl_release)
            report_fail($sformatf("scl_release expected %0d got %0d",
                                  want.scl_release, got.scl_release));
          if (got.sda_release !== want.sda_release)
            report_fail($sformatf("sda_release expected %0d got %0d",
                                  want.sda_release, got.sda_release));
          if (got.busy_res !== want.busy_res)
            report_fail($sformatf("busy_res expected %0d got %0d",
                                  want.busy_res, got.busy_res));
          if (got.done_res !== want.done_res)
            report_fail($sformatf("done_res expected %0d got %0d",
                                  want.done_res, got.done_res));
          if (got.error_flags !== want.error_flags)
            report_fail($sformatf("error_flags expected %0d got %0d",
                                  want.error_flags, got.error_flags));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        w.opcode       = in_ch.opcode;
        w.address_byte = in_ch.address_byte;
        w.data_byte    = in_ch.data_byte;
        w.scl_sample   = in_ch.scl_sample;
        w.sda_sample   = in_ch.sda_sample;
        bus_view_q.push_back(step_bus(w));
      end
    end
    n_pending <= bus_view_q.size();
    bus_busy  <= (bus_phase != BUS_IDLE);
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives tick and start words into the i2c master with random bus line levels,
// clock stretching, acks and nacks over several timing settings, and reports
// the verdict from the checker's mismatch and pending counts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  typedef enum int {SCL_FREE, SCL_STRETCH, SCL_HELD_LOW} scl_mode_t;
  typedef enum int {ACK_ALL, ACK_NONE, ACK_RANDOM} ack_mode_t;

  logic        clk;
  logic        rst_n;
  int          n_fail;
  int          n_pending;
  bit          bus_busy;
  int unsigned words_sent;
  int unsigned words_taken;
  int unsigned n_settings;
  int unsigned scl_low_left;
  bit          calm_in;
  bit          calm_out;
  logic [7:0]  cur_delay;
  logic [15:0] cur_timeout;

  i2cmbw_in_if  in_ch();
  i2cmbw_out_if out_ch();
  i2cmbw_cfg_if cfg_ch();

  i2c_master_byte_write i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  i2cmbw_checker i_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .n_fail    (n_fail),
    .n_pending (n_pending),
    .bus_busy  (bus_busy)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin : watchdog
    #16_000_000;
    $display("timeout with %0d result words outstanding", n_pending);
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stalls with calm stretches
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (words_taken % 40 == 0) calm_out = ($urandom_range(0, 3) == 0);
      stall = calm_out ? 0 : $urandom_range(0, 6);
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      words_taken++;
    end
  end

  task automatic send_word(input i2cmbw_pkg::in_word_t w);
    int unsigned gap;
    if (words_sent % 40 == 0) calm_in = ($urandom_range(0, 3) == 0);
    gap = calm_in ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= w.opcode;
    in_ch.address_byte <= w.address_byte;
    in_ch.data_byte    <= w.data_byte;
    in_ch.scl_sample   <= w.scl_sample;
    in_ch.sda_sample   <= w.sda_sample;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    words_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
  endtask

  // run plain ticks until the bus sequence is back in idle and all words are in
  task automatic settle();
    i2cmbw_pkg::in_word_t w;
    w = '0;
    w.opcode     = i2cmbw_pkg::OPC_TICK;
    w.scl_sample = 1'b1;
    hold_until_drained();
    while (bus_busy) begin
      send_word(w);
      hold_until_drained();
    end
  endtask

  task automatic write_reg(logic [i2cmbw_pkg::CFG_IDX_W-1:0] idx,
                           logic [i2cmbw_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_setting(logic [7:0] dly, logic [15:0] tmo);
    settle();
    write_reg(i2cmbw_pkg::REG_PHASE_DELAY, {8'd0, dly});
    write_reg(i2cmbw_pkg::REG_STRETCH_TIMEOUT, tmo);
    cur_delay   = dly;
    cur_timeout = tmo;
    n_settings++;
  endtask

  function automatic logic next_scl(scl_mode_t m, int unsigned burst_max);
    if (m == SCL_FREE) return 1'b1;
    if (m == SCL_HELD_LOW) return 1'b0;
    if (scl_low_left > 0) begin
      scl_low_left--;
      return 1'b0;
    end
    if ($urandom_range(0, 5) == 0) begin
      scl_low_left = $urandom_range(0, burst_max);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic next_sda(ack_mode_t m);
    case (m)
      ACK_ALL:  return 1'b0;
      ACK_NONE: return 1'b1;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // one write transaction, optionally with start words thrown in while busy
  task automatic run_txn(logic [7:0] addr, logic [7:0] data, scl_mode_t sm, ack_mode_t am,
                         int unsigned burst_max, bit noisy);
    i2cmbw_pkg::in_word_t w;
    scl_low_left   = 0;
    w.opcode       = i2cmbw_pkg::OPC_START;
    w.address_byte = addr;
    w.data_byte    = data;
    w.scl_sample   = next_scl(sm, burst_max);
    w.sda_sample   = next_sda(am);
    send_word(w);
    do begin
      w.opcode       = (noisy && $urandom_range(0, 7) == 0) ?
                       i2cmbw_pkg::OPC_START : i2cmbw_pkg::OPC_TICK;
      w.address_byte = 8'($urandom);
      w.data_byte    = 8'($urandom);
      w.scl_sample   = next_scl(sm, burst_max);
      w.sda_sample   = next_sda(am);
      send_word(w);
    end while (bus_busy);
  endtask

  task automatic run_random(int unsigned n_items, int unsigned burst_max);
    int unsigned          stop_at;
    scl_mode_t            sm;
    ack_mode_t            am;
    i2cmbw_pkg::in_word_t w;
    bit                   slow;
    stop_at = words_sent + n_items;
    slow    = (cur_delay >= 8'd16);
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) hold_until_drained();
      repeat ($urandom_range(0, 2)) begin
        w.opcode       = (!slow && $urandom_range(0, 3) == 0) ?
                         i2cmbw_pkg::OPC_START : i2cmbw_pkg::OPC_TICK;
        w.address_byte = 8'($urandom);
        w.data_byte    = 8'($urandom);
        w.scl_sample   = 1'($urandom_range(0, 1));
        w.sda_sample   = 1'($urandom_range(0, 1));
        send_word(w);
      end
      case ($urandom_range(0, 5))
        0: sm = SCL_FREE;
        5: sm = (cur_timeout <= 16'd64) ? SCL_HELD_LOW : SCL_STRETCH;
        default: sm = SCL_STRETCH;
      endcase
      am = ack_mode_t'($urandom_range(0, 2));
      run_txn(8'($urandom), 8'($urandom), sm, am, burst_max,
              !slow && $urandom_range(0, 1) != 0);
    end
  endtask

  initial begin : stimulus
    i2cmbw_pkg::in_word_t w;
    int unsigned          guard;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = i2cmbw_pkg::OPC_TICK;
    in_ch.address_byte  = '0;
    in_ch.data_byte     = '0;
    in_ch.scl_sample    = 1'b1;
    in_ch.sda_sample    = 1'b1;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = i2cmbw_pkg::REG_PHASE_DELAY;
    cfg_ch.data         = '0;
    cur_delay           = i2cmbw_pkg::PHASE_DELAY_RESET;
    cur_timeout         = i2cmbw_pkg::STRETCH_TIMEOUT_RESET;
    n_settings          = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // idle ticks straight out of reset
    w = '0;
    repeat (4) begin
      w.scl_sample = 1'($urandom_range(0, 1));
      w.sda_sample = 1'($urandom_range(0, 1));
      send_word(w);
    end
    run_txn(8'hFF, 8'h00, SCL_FREE, ACK_ALL, 0, 1'b0);
    apply_setting(8'd1, 16'hFFFF);
    // nack on both bytes while start words keep arriving
    run_txn(8'h00, 8'hFF, SCL_FREE, ACK_NONE, 0, 1'b1);
    run_txn(8'hA5, 8'h5A, SCL_STRETCH, ACK_RANDOM, 20, 1'b1);
    // zero delay and zero timeout, clock held low the whole way
    apply_setting(8'd0, 16'd0);
    run_txn(8'h81, 8'h7E, SCL_HELD_LOW, ACK_ALL, 0, 1'b0);
    run_txn(8'h3C, 8'hC3, SCL_FREE, ACK_ALL, 0, 1'b0);
    apply_setting(8'd2, 16'd3);
    run_txn(8'h01, 8'h80, SCL_STRETCH, ACK_RANDOM, 6, 1'b1);

    apply_setting(8'd1, 16'hFFFF);
    run_random(200, 12);
    apply_setting(8'd0, 16'd0);
    run_random(150, 3);
    apply_setting(8'd2, 16'd5);
    run_random(200, 9);
    apply_setting(8'd7, 16'd1);
    run_random(1, 3);
    apply_setting(8'd3, 16'd40);
    run_random(150, 60);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    guard = 0;
    while (n_pending != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    if (n_pending != 0) $display("%0d result words never arrived", n_pending);
    $display("sent %0d command and tick words across %0d timing settings, %0d mismatches",
             words_sent, n_settings, n_fail);
    if (n_fail == 0 && n_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/i2cmbw_pkg.sv
hdl/i2cmbw_if.sv
hdl/i2cmbw_cfg_regs.sv
hdl/i2cmbw_core.sv
hdl/i2cmbw_out_fifo.sv
hdl/i2c_master_byte_write.sv
hdl/i2cmbw_checker.sv
tb/i2cmbw_checker.sv
tb/tb_top.sv
